[rtl/core/wras_pkg.sv]
// package for the weighted random arm selector
// holds sizes, word types and shared constants; no dependencies
`default_nettype none

package wras_pkg;

   localparam int MAX_ARMS   = 64;
   localparam int ADDR_W     = $clog2(MAX_ARMS);
   localparam int VAL_W      = 17;
   localparam int FRAC_W     = 17;
   localparam int TOT_W      = VAL_W + ADDR_W;
   localparam int TGT_W      = TOT_W + FRAC_W;
   localparam int CSR_W      = 7;
   localparam int SUM_W      = 32;
   localparam int CNT_W      = 16;

   localparam logic [VAL_W-1:0]  VALUE_MAX  = 17'h1FFFF;
   localparam logic [FRAC_W-1:0] ONE_Q16    = 17'h10000;
   localparam logic [CSR_W-1:0]  ARMS_RESET = 7'd64;

   localparam logic CMD_UPDATE = 1'b0;
   localparam logic CMD_DRAW   = 1'b1;

   typedef struct packed {
      logic              cmd;
      logic [5:0]        arm;
      logic [SUM_W-1:0]  reward_sum;
      logic [CNT_W-1:0]  pull_count;
      logic [FRAC_W-1:0] rand_frac;
      logic              new_set;
   } req_type;

   typedef struct packed {
      logic [5:0]  chosen_arm;
      logic        no_choice;
      logic [63:0] chosen_set;
   } rsp_type;

endpackage

`default_nettype wire

[rtl/core/wras_divider.sv]
// bit-serial restoring divider for the arm mean value
// one quotient bit per cycle; uses wras_pkg
`default_nettype none

module wras_divider (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          div_start,
   input  wire [wras_pkg::SUM_W-1:0]    dividend,
   input  wire [wras_pkg::CNT_W-1:0]    divisor,
   output logic                         div_done,
   output logic [wras_pkg::VAL_W-1:0]   quotient
);
   import wras_pkg::*;

   localparam int STEPS  = SUM_W;
   localparam int STEP_W = $clog2(STEPS);

   logic [SUM_W-1:0]  quo_ff;
   logic [CNT_W:0]    rem_ff;
   logic [CNT_W-1:0]  div_ff;
   logic              zero_ff;
   logic [STEP_W-1:0] step_ff;
   logic              run_ff;
   logic              done_ff;

   logic [CNT_W:0]    shifted;
   logic              fits;

   assign shifted = {rem_ff[CNT_W-1:0], quo_ff[SUM_W-1]};
   assign fits    = shifted >= {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (div_start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (step_ff == STEP_W'(STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath, no reset needed
   always_ff @(posedge clock) begin
      if (div_start) begin
         quo_ff  <= dividend;
         rem_ff  <= '0;
         div_ff  <= divisor;
         zero_ff <= (divisor == '0);
      end else if (run_ff) begin
         rem_ff <= fits ? (shifted - {1'b0, div_ff}) : shifted;
         quo_ff <= {quo_ff[SUM_W-2:0], fits};
      end
   end

   assign div_done = done_ff;

   always_comb begin
      priority if (zero_ff) begin
         quotient = '0;
      end else if (|quo_ff[SUM_W-1:VAL_W]) begin
         quotient = VALUE_MAX;
      end else begin
         quotient = quo_ff[VAL_W-1:0];
      end
   end

endmodule

`default_nettype wire

[rtl/core/wras_value_mem.sv]
// arm value store: one write port, one read port, registered read data
// entries never written since reset read as zero; uses wras_pkg
`default_nettype none

module wras_value_mem (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          wr_en,
   input  wire [wras_pkg::ADDR_W-1:0]   wr_addr,
   input  wire [wras_pkg::VAL_W-1:0]    wr_data,
   input  wire                          rd_en,
   input  wire [wras_pkg::ADDR_W-1:0]   rd_addr,
   output logic [wras_pkg::VAL_W-1:0]   rd_data
);
   import wras_pkg::*;

   logic [VAL_W-1:0]    mem [MAX_ARMS];
   logic [MAX_ARMS-1:0] valid_ff;
   logic [VAL_W-1:0]    rd_q_ff;
   logic                rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

`default_nettype wire

[rtl/core/weighted_random_arm_selector.sv]
// top level of the weighted random arm selector (roulette wheel over arm means)
// uses wras_pkg, wras_divider and wras_value_mem
`default_nettype none

// usage
//  - input words enter on req_data and are taken at a clock edge with start high
//    and busy low; busy stays high until the word is fully processed
//  - an update word (cmd 0) runs a serial divide of reward_sum by pull_count and
//    writes the saturated Q1.16 mean into the arm value memory; no result word
//  - a draw word (cmd 1) yields exactly one result word on rsp_data, marked by a
//    one-cycle rsp_strobe; the receiver cannot stall, every strobe is a result
//  - order of work: an update loads the divider, runs its 32 divide steps, then
//    writes the memory; a draw totals the memory over the n arms in use, then
//    multiplies, then scans prefix sums until a hit or the last arm, then sets
//    the result register; the value memory has a single read port, so total and scan run in turn
//  - a new word may be accepted in the cycle the result strobe is shown
//  - csr_wr_en/csr_wr_data write arms_in_use; write only while busy is low
//  - reset clears the memory valid bits (all arm values read as zero), the
//    chosen-arm bitmap, and sets arms_in_use to 64; no clearing pass needed
//  - reads and writes of the memory never overlap: one word at a time
module weighted_random_arm_selector (
   input  wire                          clock,
   input  wire                          reset,
   input  wire                          start,
   output logic                         busy,
   input  wire wras_pkg::req_type       req_data,
   output logic                         rsp_strobe,
   output wras_pkg::rsp_type            rsp_data,
   input  wire                          csr_wr_en,
   input  wire [wras_pkg::CSR_W-1:0]    csr_wr_data
);
   import wras_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_DIV,
      S_SUM,
      S_MUL,
      S_SCAN
   } state_type;

   state_type          state_ff;
   logic [CSR_W-1:0]   arms_ff;
   logic [ADDR_W-1:0]  last_addr_ff;
   logic [ADDR_W-1:0]  iss_ff;
   logic               iss_done_ff;
   logic               rd_pend_ff;
   logic [ADDR_W-1:0]  rd_idx_ff;
   logic [TOT_W-1:0]   total_ff;
   logic [TOT_W-1:0]   prefix_ff;
   logic [TGT_W-1:0]   target_ff;
   logic [FRAC_W-1:0]  frac_ff;
   logic [ADDR_W-1:0]  upd_arm_ff;
   logic [63:0]        bitmap_ff;
   logic               rsp_strobe_ff;
   rsp_type            rsp_ff;

   logic               accept;
   logic               div_start;
   logic               div_done;
   logic [VAL_W-1:0]   div_quo;
   logic               mem_wr_en;
   logic               mem_rd_en;
   logic [VAL_W-1:0]   mem_rd_data;
   logic [TOT_W-1:0]   total_in;
   logic [TOT_W-1:0]   prefix_in;
   logic               hit;
   logic [ADDR_W-1:0]  last_addr_in;
   logic [63:0]        pick_bit;

   assign accept    = start && !busy;
   assign busy      = (state_ff != S_IDLE);
   assign div_start = accept && (req_data.cmd == CMD_UPDATE)
                      && (32'(req_data.arm) < MAX_ARMS);
   assign mem_wr_en = (state_ff == S_DIV) && div_done;
   assign mem_rd_en = ((state_ff == S_SUM) || (state_ff == S_SCAN)) && !iss_done_ff;

   // running sums over the words coming back from the memory
   assign total_in  = total_ff + TOT_W'(mem_rd_data);
   assign prefix_in = prefix_ff + TOT_W'(mem_rd_data);
   // r * T <= prefix * 65536, exact
   assign hit       = target_ff <= TGT_W'({prefix_in, 16'b0});
   assign pick_bit  = 64'(1) << rd_idx_ff;

   // clamp arms in use to 1..MAX_ARMS, kept as the last arm index
   always_comb begin
      priority if (arms_ff == '0) begin
         last_addr_in = '0;
      end else if (32'(arms_ff) > MAX_ARMS) begin
         last_addr_in = ADDR_W'(MAX_ARMS - 1);
      end else begin
         last_addr_in = ADDR_W'(arms_ff - 1'b1);
      end
   end

   wras_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_start (div_start),
      .dividend  (req_data.reward_sum),
      .divisor   (req_data.pull_count),
      .div_done  (div_done),
      .quotient  (div_quo)
   );

   wras_value_mem u_value_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (upd_arm_ff),
      .wr_data (div_quo),
      .rd_en   (mem_rd_en),
      .rd_addr (iss_ff),
      .rd_data (mem_rd_data)
   );

   // config register
   always_ff @(posedge clock) begin
      if (reset) begin
         arms_ff <= ARMS_RESET;
      end else if (csr_wr_en) begin
         arms_ff <= csr_wr_data;
      end
   end

   // sequencer, bitmap and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         bitmap_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
         rd_pend_ff    <= 1'b0;
         iss_done_ff   <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         rd_pend_ff    <= mem_rd_en;
         if (mem_rd_en) begin
            if (iss_ff == last_addr_ff) begin
               iss_done_ff <= 1'b1;
            end else begin
               iss_ff <= iss_ff + 1'b1;
            end
         end
         unique case (state_ff)
            S_IDLE: begin
               if (div_start) begin
                  state_ff <= S_DIV;
               end else if (accept && (req_data.cmd == CMD_DRAW)) begin
                  state_ff    <= S_SUM;
                  iss_ff      <= '0;
                  iss_done_ff <= 1'b0;
                  if (req_data.new_set) begin
                     bitmap_ff <= '0;
                  end
               end
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_IDLE;
               end
            end
            S_SUM: begin
               if (rd_pend_ff && (rd_idx_ff == last_addr_ff)) begin
                  state_ff <= S_MUL;
               end
            end
            S_MUL: begin
               iss_ff      <= '0;
               iss_done_ff <= 1'b0;
               if (total_ff == '0) begin
                  // zero total: no arm, bitmap untouched
                  state_ff          <= S_IDLE;
                  rsp_strobe_ff     <= 1'b1;
                  rsp_ff.chosen_arm <= '0;
                  rsp_ff.no_choice  <= 1'b1;
                  rsp_ff.chosen_set <= bitmap_ff;
               end else begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               if (rd_pend_ff && (hit || (rd_idx_ff == last_addr_ff))) begin
                  state_ff          <= S_IDLE;
                  rsp_strobe_ff     <= 1'b1;
                  rsp_ff.chosen_arm <= 6'(rd_idx_ff);
                  rsp_ff.no_choice  <= 1'b0;
                  rsp_ff.chosen_set <= bitmap_ff | pick_bit;
                  bitmap_ff         <= bitmap_ff | pick_bit;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rd_idx_ff <= iss_ff;
      if (accept) begin
         upd_arm_ff   <= ADDR_W'(req_data.arm);
         last_addr_ff <= last_addr_in;
         total_ff     <= '0;
         prefix_ff    <= '0;
         // fraction above 1.0 counts as 1.0
         frac_ff      <= req_data.rand_frac[FRAC_W-1] ? ONE_Q16 : req_data.rand_frac;
      end else begin
         if ((state_ff == S_SUM) && rd_pend_ff) begin
            total_ff <= total_in;
         end
         if ((state_ff == S_SCAN) && rd_pend_ff) begin
            prefix_ff <= prefix_in;
         end
      end
      if (state_ff == S_MUL) begin
         target_ff <= TGT_W'(frac_ff) * TGT_W'(total_ff);
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // result only ever follows the multiply or scan step
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == S_MUL || $past(state_ff) == S_SCAN))
      else $error("result strobe without a draw in flight");

   a_no_choice_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && rsp_ff.no_choice |-> rsp_ff.chosen_arm == '0)
      else $error("no-choice result carries an arm");

   a_arm_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.no_choice |-> rsp_ff.chosen_arm <= 6'(last_addr_ff))
      else $error("chosen arm beyond arms in use");

   a_set_has_arm: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff && !rsp_ff.no_choice |-> rsp_ff.chosen_set[rsp_ff.chosen_arm])
      else $error("chosen set misses the chosen arm");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept && (req_data.cmd == CMD_DRAW) |=> busy)
      else $error("draw accepted without going busy");

endmodule

`default_nettype wire
